FILE: design/base64_stream_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// base64_stream_decoder_core_defines.svh
// Assertion macros shared by the checker of the Base64 stream decoder.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_CORE_DEFINES_SVH
`define BASE64_STREAM_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define B64D_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("b64d assertion failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define B64D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("b64d assertion failed");

`endif

FILE: design/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, constants and the character map of the Base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QADDR_W = $clog2(QDEPTH);

    localparam logic [7:0] PAD_MARK = 8'd254;
    localparam logic [7:0] NO_VALUE = 8'd255;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_INVALID    = 3'd1,
        ST_FULL       = 3'd2,
        ST_PADDING    = 3'd3,
        ST_INCOMPLETE = 3'd4
    } status_t;

    // One queue entry: the results that one accepted character causes.
    typedef struct packed {
        logic [1:0]  nbytes;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic        has_status;
        status_t     code;
        logic [31:0] position;
        logic [31:0] space;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    function automatic logic [7:0] map_char(input logic [7:0] c);
        logic [7:0] v;
        unique case (c) inside
            [8'h41:8'h5a]: v = c - 8'h41;
            [8'h61:8'h7a]: v = c - 8'h61 + 8'd26;
            [8'h30:8'h39]: v = c - 8'h30 + 8'd52;
            8'h2b:         v = 8'd62;
            8'h2f:         v = 8'd63;
            8'h3d:         v = PAD_MARK;
            default:       v = NO_VALUE;
        endcase
        return v;
    endfunction

endpackage

FILE: design/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, keeps group and stream state, and queues per-character
// result commands.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] char_code
    input  logic                s_tlast,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data,
    input  b64d_pkg::fifo_stat_t fifo_stat,
    output logic                push,
    output b64d_pkg::cmd_t      cmd
);

    logic [31:0] cap_reg, cap_next;
    logic [1:0]  gc_reg, gc_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] br_reg, br_next;
    logic        drop_reg, drop_next;
    logic [7:0]  gv_reg [0:2];

    logic        accept;
    logic [7:0]  v;
    logic        gv_we;
    logic [7:0]  b0, b1, b2;
    logic [31:0] br_dec;
    logic        fresh;
    logic        err;

    assign s_tready = !fifo_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign v        = b64d_pkg::map_char(s_tdata);
    assign gv_we    = accept && !drop_reg && (v != b64d_pkg::NO_VALUE) && (gc_reg != 2'd3);

    assign b0 = {gv_reg[0][5:0], 2'b00} | {4'b0000, gv_reg[1][7:4]};
    assign b1 = {gv_reg[1][3:0], 4'b0000} | {2'b00, gv_reg[2][7:2]};
    assign b2 = {gv_reg[2][1:0], 6'b000000} | v;

    always_comb begin
        cap_next  = cap_reg;
        gc_next   = gc_reg;
        pos_next  = pos_reg;
        br_next   = br_reg;
        drop_next = drop_reg;
        fresh     = 1'b0;
        err       = 1'b0;
        br_dec    = br_reg;
        cmd       = '0;
        cmd.byte0 = b0;
        cmd.byte1 = b1;
        cmd.byte2 = b2;
        cmd.space = br_reg;

        if (accept) begin
            if (drop_reg) begin
                fresh = s_tlast;
            end else begin
                pos_next = pos_reg + 32'd1;
                if (v == b64d_pkg::NO_VALUE) begin
                    err            = 1'b1;
                    cmd.has_status = 1'b1;
                    cmd.code       = b64d_pkg::ST_INVALID;
                    cmd.position   = pos_next;
                end else if (gc_reg != 2'd3) begin
                    gc_next = gc_reg + 2'd1;
                    if (s_tlast) begin
                        cmd.has_status = 1'b1;
                        cmd.code       = b64d_pkg::ST_INCOMPLETE;
                        fresh          = 1'b1;
                    end
                end else begin
                    gc_next = 2'd0;
                    // Budget is checked before each byte; a full group charges it at once.
                    if (br_reg == 32'd0) begin
                        err = 1'b1;
                        cmd.code = b64d_pkg::ST_FULL;
                    end else if (gv_reg[2] == b64d_pkg::PAD_MARK) begin
                        cmd.nbytes = 2'd1;
                        if (v == b64d_pkg::PAD_MARK) begin
                            br_dec = br_reg - 32'd1;
                        end else begin
                            err = 1'b1;
                            cmd.code = b64d_pkg::ST_PADDING;
                        end
                    end else if (br_reg == 32'd1) begin
                        cmd.nbytes = 2'd1;
                        err = 1'b1;
                        cmd.code = b64d_pkg::ST_FULL;
                    end else if (v == b64d_pkg::PAD_MARK) begin
                        cmd.nbytes = 2'd2;
                        br_dec = br_reg - 32'd2;
                    end else if (br_reg == 32'd2) begin
                        cmd.nbytes = 2'd2;
                        err = 1'b1;
                        cmd.code = b64d_pkg::ST_FULL;
                    end else begin
                        cmd.nbytes = 2'd3;
                        br_dec = br_reg - 32'd3;
                    end
                    if (err) begin
                        cmd.has_status = 1'b1;
                    end else begin
                        br_next   = br_dec;
                        cmd.space = br_dec;
                        if (s_tlast) begin
                            cmd.has_status = 1'b1;
                            cmd.code       = b64d_pkg::ST_OK;
                            fresh          = 1'b1;
                        end
                    end
                end
                if (err) begin
                    if (s_tlast) begin
                        fresh = 1'b1;
                    end else begin
                        drop_next = 1'b1;
                    end
                end
            end
        end

        if (fresh) begin
            gc_next   = 2'd0;
            pos_next  = 32'd0;
            br_next   = cap_reg;
            drop_next = 1'b0;
        end

        if (cfg_wr_en) begin
            cap_next = cfg_wr_data;
            if (pos_reg == 32'd0 && !drop_reg) begin
                br_next = cfg_wr_data;
            end
        end
    end

    assign push = accept && ((cmd.nbytes != 2'd0) || cmd.has_status);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg  <= '1;
            gc_reg   <= 2'd0;
            pos_reg  <= 32'd0;
            br_reg   <= '1;
            drop_reg <= 1'b0;
        end else begin
            cap_reg  <= cap_next;
            gc_reg   <= gc_next;
            pos_reg  <= pos_next;
            br_reg   <= br_next;
            drop_reg <= drop_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (gv_we) begin
            gv_reg[gc_reg] <= v;
        end
    end

endmodule

FILE: design/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module b64d_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  b64d_pkg::cmd_t       wr_cmd,
    input  logic                 pop,
    output b64d_pkg::cmd_t       head,
    output b64d_pkg::fifo_stat_t stat
);

    localparam logic [b64d_pkg::QADDR_W:0] FULL_COUNT = (b64d_pkg::QADDR_W + 1)'(b64d_pkg::QDEPTH);
    localparam logic [b64d_pkg::QADDR_W-1:0] PTR_ONE  = b64d_pkg::QADDR_W'(1);
    localparam logic [b64d_pkg::QADDR_W:0] COUNT_ONE  = (b64d_pkg::QADDR_W + 1)'(1);

    b64d_pkg::cmd_t                mem_reg [0:b64d_pkg::QDEPTH-1];
    logic [b64d_pkg::QADDR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [b64d_pkg::QADDR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [b64d_pkg::QADDR_W:0]    count_reg, count_next;
    logic                          do_push, do_pop;

    assign stat.full  = (count_reg == FULL_COUNT);
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_ONE : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_ONE : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + COUNT_ONE;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - COUNT_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

FILE: design/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Unpacks queued commands into result words and drives the output register.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  b64d_pkg::cmd_t       head,
    input  b64d_pkg::fifo_stat_t stat,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [79:0]          m_tdata,  // [7:0] data_byte, [10:8] status_code,
                                           // [42:11] error_position, [74:43] space_left
    output logic                 m_tuser,  // is_status
    output logic                 m_tlast   // last_result
);

    logic [1:0]  sub_reg, sub_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [79:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;
    logic        m_tlast_reg, m_tlast_next;

    logic        load;
    logic        is_data;
    logic        last_item;
    logic [7:0]  sel_byte;

    assign load    = !stat.empty && (!m_tvalid_reg || m_tready);
    assign is_data = (sub_reg < head.nbytes);
    assign last_item = is_data ? (({1'b0, sub_reg} + 3'd1 == {1'b0, head.nbytes})
                                  && !head.has_status)
                               : 1'b1;
    assign pop = load && last_item;

    always_comb begin
        case (sub_reg)
            2'd0:    sel_byte = head.byte0;
            2'd1:    sel_byte = head.byte1;
            default: sel_byte = head.byte2;
        endcase
    end

    always_comb begin
        sub_next      = sub_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
            sub_next      = last_item ? 2'd0 : sub_reg + 2'd1;
            if (is_data) begin
                m_tdata_next = {72'd0, sel_byte};
                m_tuser_next = 1'b0;
                m_tlast_next = 1'b0;
            end else begin
                m_tdata_next = {5'd0, head.space, head.position, head.code, 8'd0};
                m_tuser_next = 1'b1;
                m_tlast_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg      <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            sub_reg      <= sub_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: design/base64_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Streaming Base64 decoder: characters in, data bytes and one status per
// stream out.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one character per word (s_tdata), s_tlast on the last
//   character of a stream. m_ channel carries decoded bytes (m_tuser low) and
//   one status word per stream (m_tuser high, m_tlast high) with code,
//   error position and remaining byte budget.
//   cfg_wr_en/cfg_wr_data load the byte budget; write only while idle.
//   Throughput: one character per cycle in while s_tready is high, one result
//   word per cycle out while m_tready is high. A character's first result
//   passes through the queue write, then the output register; its remaining
//   results (up to four in all) follow one a cycle while m_tready is high.
//   The front decodes a character in the accepting cycle into a four-entry
//   command queue; the back unpacks entries into the output register.
//   When m_tready is low the output word holds, the queue fills, and
//   s_tready drops once all four entries are taken.
//   Reset: queue and output empty, budget 0xFFFFFFFF, a fresh stream ready.
// ----------------------------------------------------------------------------
module base64_stream_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_of_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [7:0] data_byte, [10:8] status_code,
                                   // [42:11] error_position, [74:43] space_left
    output logic        m_tuser,   // is_status
    output logic        m_tlast,   // last_result
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    b64d_pkg::cmd_t       wr_cmd;
    b64d_pkg::cmd_t       head;
    b64d_pkg::fifo_stat_t stat;
    logic                 push;
    logic                 pop;

    b64d_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .fifo_stat  (stat),
        .push       (push),
        .cmd        (wr_cmd)
    );

    b64d_queue u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (push),
        .wr_cmd (wr_cmd),
        .pop    (pop),
        .head   (head),
        .stat   (stat)
    );

    b64d_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .stat    (stat),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

FILE: design/b64d_checker.sv
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks of the Base64 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_core_defines.svh"

module b64d_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // Data words carry only the byte; status words always close the stream.
    `B64D_ASSERT_NOW(a_data_clean, m_tvalid && !m_tuser, m_tdata[79:8] == 72'd0 && !m_tlast)
    `B64D_ASSERT_NOW(a_status_last, m_tvalid && m_tuser, m_tlast && m_tdata[7:0] == 8'd0)
    `B64D_ASSERT_NOW(a_code_range, m_tvalid && m_tuser,
        m_tdata[10:8] <= 3'd4 && m_tdata[79:75] == 5'd0)
    // Only an invalid-character status reports a position, and never zero.
    `B64D_ASSERT_NOW(a_pos_invalid, m_tvalid && m_tuser,
        (m_tdata[10:8] == 3'd1) == (m_tdata[42:11] != 32'd0))
    `B64D_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (.*);

FILE: tb/tb_base64_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder_core
// Self-checking bench for the Base64 stream decoder: characters go in as
// streams, and every decoded byte and status word is checked against an
// in-bench decoder across several byte budgets and handshake patterns.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RUN_LIMIT = 200000;
    localparam logic [7:0]  PAD_CHAR  = 8'h3d;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } char_word_t;

    typedef struct packed {
        logic              is_status;
        logic [7:0]        data_byte;
        b64d_pkg::status_t code;
        logic [31:0]       err_pos;
        logic [31:0]       space;
        logic              last;
    } result_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'h00;
    logic        s_tlast     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = 32'h0;

    char_word_t  char_backlog[$];
    result_t     decoded_words[$];

    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned hold_req     = 0;
    int unsigned hold_seen    = 0;
    int unsigned hold_left    = 0;
    int unsigned cycles       = 0;
    int unsigned errors       = 0;

    // decoder state
    logic [31:0] byte_budget;
    logic [7:0]  grp[3];
    logic [1:0]  grp_cnt;
    logic [31:0] char_pos;
    logic [31:0] budget_left;
    logic        dropping;

    base64_stream_decoder_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [7:0] char_value(logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5a) return c - 8'h41;
        if (c >= 8'h61 && c <= 8'h7a) return c - 8'h61 + 8'd26;
        if (c >= 8'h30 && c <= 8'h39) return c - 8'h30 + 8'd52;
        if (c == 8'h2b) return 8'd62;
        if (c == 8'h2f) return 8'd63;
        if (c == PAD_CHAR) return b64d_pkg::PAD_MARK;
        return b64d_pkg::NO_VALUE;
    endfunction

    function automatic logic [7:0] alphabet_char(int unsigned i);
        if (i < 26) return 8'h41 + 8'(i);
        if (i < 52) return 8'h61 + 8'(i - 26);
        if (i < 62) return 8'h30 + 8'(i - 52);
        if (i == 62) return 8'h2b;
        return 8'h2f;
    endfunction

    function automatic void start_stream();
        grp_cnt     = 2'd0;
        char_pos    = 32'd0;
        budget_left = byte_budget;
        dropping    = 1'b0;
    endfunction

    function automatic void load_budget(logic [31:0] value);
        byte_budget = value;
        if (char_pos == 0 && !dropping) budget_left = value;
    endfunction

    function automatic void push_byte(logic [7:0] b);
        decoded_words.push_back('{1'b0, b, b64d_pkg::ST_OK, 32'd0, 32'd0, 1'b0});
    endfunction

    function automatic void push_status(b64d_pkg::status_t code, logic [31:0] pos);
        decoded_words.push_back('{1'b1, 8'd0, code, pos, budget_left, 1'b1});
    endfunction

    // Emit the bytes of a full group; partial output stands if the budget runs out.
    function automatic b64d_pkg::status_t finish_group(logic [7:0] v3);
        logic [7:0] c0, c1, c2;
        b64d_pkg::status_t st;
        c0 = grp[0];
        c1 = grp[1];
        c2 = grp[2];
        st = b64d_pkg::ST_OK;
        if (budget_left == 0) begin
            st = b64d_pkg::ST_FULL;
        end else begin
            push_byte({c0[5:0], 2'b00} | {4'b0000, c1[7:4]});
            if (c2 == b64d_pkg::PAD_MARK) begin
                if (v3 == b64d_pkg::PAD_MARK) budget_left = budget_left - 1;
                else st = b64d_pkg::ST_PADDING;
            end else if (budget_left == 1) begin
                st = b64d_pkg::ST_FULL;
            end else begin
                push_byte({c1[3:0], 4'b0000} | {2'b00, c2[7:2]});
                if (v3 == b64d_pkg::PAD_MARK) begin
                    budget_left = budget_left - 2;
                end else if (budget_left == 2) begin
                    st = b64d_pkg::ST_FULL;
                end else begin
                    push_byte({c2[1:0], 6'd0} | v3);
                    budget_left = budget_left - 3;
                end
            end
        end
        return st;
    endfunction

    function automatic void decode_char(logic [7:0] c, logic eos);
        logic [7:0] v;
        b64d_pkg::status_t st;
        if (dropping) begin
            if (eos) start_stream();
        end else begin
            char_pos = char_pos + 1;
            v = char_value(c);
            if (v == b64d_pkg::NO_VALUE) begin
                push_status(b64d_pkg::ST_INVALID, char_pos);
                if (eos) start_stream();
                else dropping = 1'b1;
            end else begin
                st = b64d_pkg::ST_OK;
                if (grp_cnt < 3) begin
                    grp[grp_cnt] = v;
                    grp_cnt = grp_cnt + 2'd1;
                end else begin
                    grp_cnt = 2'd0;
                    st = finish_group(v);
                end
                if (st != b64d_pkg::ST_OK) begin
                    push_status(st, 32'd0);
                    if (eos) start_stream();
                    else dropping = 1'b1;
                end else if (eos) begin
                    push_status((grp_cnt != 0) ? b64d_pkg::ST_INCOMPLETE : b64d_pkg::ST_OK,
                                32'd0);
                    start_stream();
                end
            end
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $realtime, name, want, got);
            errors++;
        end
    endfunction

    // sender: one word per handshake, random gaps
    always @(posedge aclk) begin
        char_word_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) decode_char(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (char_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    nxt = char_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.code;
                    s_tlast  <= nxt.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver ready: random stalls, or a long hold when requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= 300;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_words.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual tuser=%0b tlast=%0b tdata=%h",
                         $realtime, m_tuser, m_tlast, m_tdata);
                errors++;
            end else begin
                want = decoded_words.pop_front();
                check_field("is_status", want.is_status, m_tuser);
                check_field("data_byte", want.data_byte, m_tdata[7:0]);
                check_field("status_code", want.code, m_tdata[10:8]);
                check_field("error_position", want.err_pos, m_tdata[42:11]);
                check_field("space_left", want.space, m_tdata[74:43]);
                check_field("last_result", want.last, m_tlast);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void add_char(logic [7:0] c, logic last);
        char_backlog.push_back('{c, last});
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1);
    endfunction

    function automatic logic [7:0] any_alpha();
        return alphabet_char($urandom_range(0, 63));
    endfunction

    // Mostly well-formed streams with random content, some broken ones and noise.
    function automatic int add_random_stream();
        logic [7:0] txt[$];
        logic [7:0] c2, bad;
        int unsigned kind, spot;
        int n;
        kind = $urandom_range(0, 99);
        if (kind >= 92) begin
            repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 3)) repeat (4) txt.push_back(any_alpha());
            if (kind < 55) begin
                case ($urandom_range(0, 2))
                    0: repeat (4) txt.push_back(any_alpha());
                    1: begin
                        repeat (3) txt.push_back(any_alpha());
                        txt.push_back(PAD_CHAR);
                    end
                    default: begin
                        repeat (2) txt.push_back(any_alpha());
                        repeat (2) txt.push_back(PAD_CHAR);
                    end
                endcase
            end else if (kind < 65) begin
                repeat ($urandom_range(1, 3)) txt.push_back(any_alpha());
            end else if (kind < 75) begin
                repeat (2) txt.push_back(any_alpha());
                txt.push_back(PAD_CHAR);
                txt.push_back(any_alpha());
            end else if (kind < 82) begin
                // pad characters early in the group
                repeat (2) txt.push_back($urandom_range(0, 1) ? PAD_CHAR : any_alpha());
                c2 = $urandom_range(0, 1) ? PAD_CHAR : any_alpha();
                txt.push_back(c2);
                txt.push_back((c2 == PAD_CHAR || $urandom_range(0, 1)) ? PAD_CHAR : any_alpha());
            end else begin
                repeat (4) txt.push_back(any_alpha());
                spot = $urandom_range(0, txt.size() - 1);
                bad = 8'($urandom_range(0, 255));
                while (char_value(bad) != b64d_pkg::NO_VALUE) bad = 8'($urandom_range(0, 255));
                txt[spot] = bad;
            end
        end
        n = 0;
        foreach (txt[i]) begin
            add_char(txt[i], i == txt.size() - 1);
            // characters after an invalid one are only dropped
            if (n == i) n++;
            if (char_value(txt[i]) == b64d_pkg::NO_VALUE) n = -n;
        end
        return (n < 0) ? -n : n;
    endfunction

    function automatic void add_random_items(int target);
        int count;
        count = 0;
        while (count < target) count += add_random_stream();
    endfunction

    task automatic wait_drained();
        while (char_backlog.size() != 0 || s_tvalid || decoded_words.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_budget(logic [31:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        load_budget(value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic void set_idling(int unsigned tx_pct, int unsigned rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endfunction

    initial begin
        byte_budget = 32'hffff_ffff;
        grp[0] = 8'd0;
        grp[1] = 8'd0;
        grp[2] = 8'd0;
        start_stream();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: full group, two and one byte groups, early pad, bad pad,
        // invalid mid-stream, invalid on the last word, incomplete group
        set_idling(0, 0);
        add_text("+/9z");
        add_text("TWE=");
        add_text("TQ==");
        add_text("==//");
        add_text("TQ=A");
        add_char(8'h41, 1'b0);
        add_char(8'h00, 1'b0);
        add_char(8'h42, 1'b1);
        add_char(8'hff, 1'b1);
        add_text("AB");
        wait_drained();

        write_budget(32'd7);
        set_idling(56, 0);
        add_random_items(50);
        wait_drained();

        write_budget(32'd0);
        set_idling(0, 56);
        add_random_items(30);
        wait_drained();

        // long receiver hold while the sender keeps offering words
        write_budget(32'hffff_ffff);
        set_idling(21, 21);
        hold_req = hold_req + 1;
        add_random_items(60);
        wait_drained();

        // sender pauses mid-phase until every result has arrived
        write_budget($urandom_range(1, 12));
        set_idling(0, 0);
        add_random_items(30);
        wait_drained();
        add_random_items(30);
        wait_drained();

        write_budget(32'd3);
        set_idling(21, 21);
        add_random_items(50);
        wait_drained();

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: base64_stream_decoder_core.f
+incdir+design
design/b64d_pkg.sv
design/b64d_front.sv
design/b64d_queue.sv
design/b64d_back.sv
design/base64_stream_decoder_core.sv
design/b64d_checker.sv
tb/tb_base64_stream_decoder_core.sv
